[sv/tach_pkg.sv]
// ----------------------------------------------------------------------------
// Tachometer rpm averager package
// Shared types and constants: register map, configuration bundle, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tach_pkg;

  // Field and register widths fixed by the register map and result format.
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_GLITCH   = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd500;
  localparam logic [CFG_W-1:0] GLITCH_RST   = 16'd10000;
  localparam logic [CFG_W-1:0] SCALE_RST    = 16'd30000;

  typedef struct packed {
    logic [CFG_W-1:0] interval_ms;
    logic [CFG_W-1:0] glitch_limit;
    logic [CFG_W-1:0] rpm_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MULT,
    ST_RATE_DIV,
    ST_WRITE,
    ST_SUM,
    ST_MEAN_START,
    ST_MEAN_DIV,
    ST_MEAN_DONE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // an input request is taken this cycle
    logic decide;       // latch whether the interval has passed
    logic start_rate;   // register the product and load the divider
    logic div_step;     // one restoring division step
    logic write_ring;   // glitch filter, ring write, counter clear
    logic accum;        // add one ring entry to the running sum
    logic start_mean;   // load the divider with sum and entry count
    logic finish_mean;  // store the new filtered rpm
    logic load_out;     // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;      // input request is a read request
    logic due;          // the update interval has passed
    logic div_done;     // divider has finished its steps
    logic sum_last;     // last ring entry is being summed
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

[sv/tach_ifs.sv]
// ----------------------------------------------------------------------------
// Tachometer rpm averager channels
// Valid/ready channels for input requests and for rpm results.
// ----------------------------------------------------------------------------
interface tach_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_ms;

  modport source (output valid, output kind, output now_ms, input ready);
  modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

interface tach_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rpm_value;
  logic        recomputed;

  modport source (output valid, output rpm_value, output recomputed, input ready);
  modport sink   (input valid, input rpm_value, input recomputed, output ready);
endinterface

[sv/tach_ctrl.sv]
// ----------------------------------------------------------------------------
// Tachometer rpm averager controller
// Sequences one request at a time: edge counting, interval check, rate
// division, ring update, averaging pass, mean division and result hand-off.
// ----------------------------------------------------------------------------
module tach_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tach_pkg::sts_t  sts,
  output tach_pkg::cmd_t  cmd
);
  import tach_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.is_read) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = sts.due ? ST_MULT : ST_EMIT;
      end
      ST_MULT: begin
        state_next = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        if (sts.div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sts.sum_last) begin
          state_next = ST_MEAN_START;
        end
      end
      ST_MEAN_START: begin
        state_next = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        if (sts.div_done) begin
          state_next = ST_MEAN_DONE;
        end
      end
      ST_MEAN_DONE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_MULT: begin
        cmd.start_rate = 1'b1;
      end
      ST_RATE_DIV: begin
        cmd.div_step = !sts.div_done;
      end
      ST_WRITE: begin
        cmd.write_ring = 1'b1;
      end
      ST_SUM: begin
        cmd.accum = 1'b1;
      end
      ST_MEAN_START: begin
        cmd.start_mean = 1'b1;
      end
      ST_MEAN_DIV: begin
        cmd.div_step = !sts.div_done;
      end
      ST_MEAN_DONE: begin
        cmd.finish_mean = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[sv/tach_dp.sv]
// ----------------------------------------------------------------------------
// Tachometer rpm averager datapath
// Pulse counter, time stamp, shared restoring divider, reading ring with its
// averaging accumulator, filtered rpm and the output register.
// ----------------------------------------------------------------------------
module tach_dp #(
  parameter int unsigned HISTORY_DEPTH = 5,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tach_pkg::cfg_t                cfg,
  input  tach_pkg::cmd_t                cmd,
  output tach_pkg::sts_t                sts,
  input  logic                          in_kind,
  input  logic [tach_pkg::TIME_W-1:0]   in_now,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tach_pkg::RPM_W-1:0]    out_rpm,
  output logic                          out_recomputed
);
  import tach_pkg::*;

  // Product width, ring index width, entry count width and sum width.
  localparam int unsigned PW   = COUNT_WIDTH + CFG_W;
  localparam int unsigned IDXW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned NZW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW   = RPM_W + NZW;
  localparam int unsigned STW  = $clog2(PW + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(HISTORY_DEPTH - 1);

  logic [COUNT_WIDTH-1:0] edge_count;
  logic [TIME_W-1:0]      last_update_time;
  logic [TIME_W-1:0]      now_l;
  logic [RPM_W-1:0]       filtered_rpm;
  logic [RPM_W-1:0]       reading;
  logic [RPM_W-1:0]       ring [HISTORY_DEPTH];
  logic [IDXW-1:0]        ring_pointer;
  logic [IDXW-1:0]        sum_idx;
  logic [SW-1:0]          sum;
  logic [NZW-1:0]         nonzero;
  logic                   updated;

  // Divider registers: quotient shifts in where the dividend shifts out.
  logic [PW-1:0]          div_num;
  logic [TIME_W-1:0]      div_den;
  logic [TIME_W-1:0]      div_rem;
  logic [STW-1:0]         div_steps;

  logic [TIME_W-1:0]      elapsed;
  logic [TIME_W:0]        rem_shift;
  logic [TIME_W:0]        rem_diff;
  logic                   rem_fits;
  logic [PW-1:0]          product;
  logic [RPM_W-1:0]       reading_next;

  // Elapsed time modulo the time width, and the interval check.
  assign elapsed = now_l - last_update_time;

  // One restoring division step.
  assign rem_shift = {div_rem, div_num[PW-1]};
  assign rem_diff  = rem_shift - {1'b0, div_den};
  assign rem_fits  = !rem_diff[TIME_W];

  // Pulses times scale at full width.
  assign product = PW'(edge_count) * PW'(cfg.rpm_scale);

  // Readings above the glitch limit keep the previous rpm.
  assign reading_next = (div_num > PW'(cfg.glitch_limit)) ? filtered_rpm
                                                          : div_num[RPM_W-1:0];

  assign sts.is_read  = in_kind;
  assign sts.due      = elapsed >= TIME_W'(cfg.interval_ms);
  assign sts.div_done = (div_steps == '0);
  assign sts.sum_last = (sum_idx == LAST_IDX);
  assign sts.out_free = !out_valid || out_ready;

  // Measurement state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count       <= '0;
      last_update_time <= '0;
      filtered_rpm     <= '0;
      ring_pointer     <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (cmd.accept && !in_kind) begin
        edge_count <= edge_count + 1'b1;
      end
      if (cmd.write_ring) begin
        ring[ring_pointer] <= reading_next;
        ring_pointer       <= (ring_pointer == LAST_IDX) ? '0 : ring_pointer + 1'b1;
        edge_count         <= '0;
        last_update_time   <= now_l;
      end
      if (cmd.finish_mean) begin
        filtered_rpm <= (nonzero == '0) ? reading : div_num[RPM_W-1:0];
      end
    end
  end

  // Request time, update flag, reading and averaging accumulator.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_l <= in_now;
    end
    if (cmd.decide) begin
      updated <= sts.due;
    end
    if (cmd.write_ring) begin
      reading <= reading_next;
      sum     <= '0;
      nonzero <= '0;
      sum_idx <= '0;
    end
    if (cmd.accum) begin
      if (ring[sum_idx] != '0) begin
        sum     <= sum + SW'(ring[sum_idx]);
        nonzero <= nonzero + 1'b1;
      end
      sum_idx <= sum_idx + 1'b1;
    end
  end

  // Shared divider: rate division first, then the mean of the ring.
  always_ff @(posedge clk) begin
    if (cmd.start_rate) begin
      div_num   <= product;
      div_den   <= (elapsed == '0) ? TIME_W'(1) : elapsed;
      div_rem   <= '0;
      div_steps <= STW'(PW);
    end else if (cmd.start_mean) begin
      div_num   <= {sum, {(PW - SW){1'b0}}};
      div_den   <= TIME_W'(nonzero);
      div_rem   <= '0;
      div_steps <= STW'(SW);
    end else if (cmd.div_step) begin
      div_num   <= {div_num[PW-2:0], rem_fits};
      div_rem   <= rem_fits ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
      div_steps <= div_steps - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rpm        <= filtered_rpm;
      out_recomputed <= updated;
    end
  end

endmodule

[sv/tachometer_rpm_averager.sv]
// Flow: an edge request is taken in the idle state and gives no result; a read request
// with no update passes the decide state and waits in the emit state until the output register can take its result.
// An update runs the bit-serial divider twice, first for the rate and then for the
// mean of the ring, with the ring update and the averaging pass in between.
// Throughput: one request at a time; edges are taken every cycle when idle.
// Reset: synchronous; clears counter, time stamp, rpm and ring, restores register defaults.
// ----------------------------------------------------------------------------
// Tachometer rpm averager
// Counts tachometer edges and, on read requests, recomputes a glitch-filtered
// moving-average rpm once per update interval.
// ----------------------------------------------------------------------------
module tachometer_rpm_averager #(
  parameter int unsigned HISTORY_DEPTH = 5,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tach_pkg::ADDR_W-1:0]   paddr,
  input  logic [tach_pkg::DATA_W-1:0]   pwdata,
  output logic [tach_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  tach_in_if.sink                       in_ch,
  tach_out_if.source                    out_ch
);
  import tach_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ms  <= INTERVAL_RST;
      cfg.glitch_limit <= GLITCH_RST;
      cfg.rpm_scale    <= SCALE_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_INTERVAL: cfg.interval_ms  <= pwdata[CFG_W-1:0];
        REG_GLITCH:   cfg.glitch_limit <= pwdata[CFG_W-1:0];
        REG_SCALE:    cfg.rpm_scale    <= pwdata[CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_INTERVAL: prdata = DATA_W'(cfg.interval_ms);
      REG_GLITCH:   prdata = DATA_W'(cfg.glitch_limit);
      REG_SCALE:    prdata = DATA_W'(cfg.rpm_scale);
      default:      prdata = '0;
    endcase
  end

  tach_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tach_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_now         (in_ch.now_ms),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_rpm        (out_ch.rpm_value),
    .out_recomputed (out_ch.recomputed)
  );

endmodule
